@@ design/fmbq_pkg.sv @@
// fmbq_pkg: shared types and constants of the front/middle/back queue.
// Operation and status codes, controller command bundle, default sizes.
// No dependencies.
package fmbq_pkg;

  localparam int DEF_CAPACITY   = 1024;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int KIND_W         = 3;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT,
    KIND_PUSH_MIDDLE,
    KIND_PUSH_BACK,
    KIND_POP_FRONT,
    KIND_POP_MIDDLE,
    KIND_POP_BACK
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE,
    ST_EMPTY,
    ST_FULL
  } status_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
  } fmbq_cmd_t;

endpackage

@@ design/fmbq_ram.sv @@
// fmbq_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module fmbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/fmbq_ctrl.sv @@
// fmbq_ctrl: sequencer of the queue, idle / read pass / write pass.
// Depends on fmbq_pkg.
module fmbq_ctrl
  import fmbq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output fmbq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   load;

  assign load = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == S_WRITE);
      unique case (state_q)
        S_IDLE: begin
          if (load) begin
            state_q <= S_READ;
            busy_q  <= 1'b1;
          end
        end
        S_READ: begin
          state_q <= S_WRITE;
          busy_q  <= 1'b0;
        end
        S_WRITE: begin
          if (load) begin
            state_q <= S_READ;
            busy_q  <= 1'b1;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o.load = load;
  assign cmd_o.rd   = (state_q == S_READ);
  assign cmd_o.wr   = (state_q == S_WRITE);
  assign busy_o     = busy_q;
  assign done_o     = done_q;

endmodule

@@ design/fmbq_dp.sv @@
// fmbq_dp: datapath, two half rings (head/count) over two RAMs, op decode.
// Depends on fmbq_pkg and fmbq_ram.
module fmbq_dp
  import fmbq_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fmbq_cmd_t                 cmd_i,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic signed [VALUE_W-1:0] popped_value_o,
  output logic [STATUS_W-1:0]       status_o
);

  localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
  localparam int PW         = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int CW         = $clog2(HALF_DEPTH + 1);
  localparam int SW         = CW + 1;
  localparam logic [SW-1:0] HD_S     = SW'(HALF_DEPTH);
  localparam logic [SW-1:0] CAP_S    = SW'(CAPACITY);
  localparam logic [PW-1:0] LAST_IDX = PW'(HALF_DEPTH - 1);
  localparam logic [CW-1:0] ONE_C    = CW'(1);

  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] h, input logic [CW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(i);
    if (s >= HD_S) begin
      s = s - HD_S;
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] h);
    return (h == LAST_IDX) ? '0 : h + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] h);
    return (h == '0) ? LAST_IDX : h - PW'(1);
  endfunction

  logic [KIND_W-1:0]     kind_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [PW-1:0]         fh_q, fh_d, bh_q, bh_d;
  logic [CW-1:0]         fc_q, fc_d, bc_q, bc_d;
  logic [DATA_WIDTH-1:0] ret_q, ret_d;
  logic [STATUS_W-1:0]   st_q, st_d;

  logic [63:0]           val_ext;
  logic [63:0]           ret_ext;
  logic [SW-1:0]         total;
  logic                  eq, full, f_empty, b_empty;
  logic [PW-1:0]         f_last, f_end, f_prev, b_last, b_end, b_prev;

  logic                  f_we, b_we;
  logic [PW-1:0]         f_waddr, b_waddr, f_raddr, b_raddr;
  logic [DATA_WIDTH-1:0] f_wdata, b_wdata, f_rdata, b_rdata;

  assign val_ext = {32'd0, value_i};
  assign total   = SW'(fc_q) + SW'(bc_q);
  assign eq      = (fc_q == bc_q);
  assign full    = (total >= CAP_S);
  assign f_empty = (fc_q == '0);
  assign b_empty = (bc_q == '0);
  assign f_last  = ring_add(fh_q, fc_q - ONE_C);
  assign f_end   = ring_add(fh_q, fc_q);
  assign f_prev  = ring_dec(fh_q);
  assign b_last  = ring_add(bh_q, bc_q - ONE_C);
  assign b_end   = ring_add(bh_q, bc_q);
  assign b_prev  = ring_dec(bh_q);

  assign f_raddr = (kind_q == KIND_POP_FRONT) ? fh_q : f_last;
  assign b_raddr = (kind_q == KIND_POP_BACK) ? b_last : bh_q;

  always_comb begin
    fh_d    = fh_q;
    fc_d    = fc_q;
    bh_d    = bh_q;
    bc_d    = bc_q;
    ret_d   = '0;
    st_d    = ST_DONE;
    f_we    = 1'b0;
    f_waddr = f_end;
    f_wdata = val_q;
    b_we    = 1'b0;
    b_waddr = b_prev;
    b_wdata = f_rdata;
    if (cmd_i.wr) begin
      unique case (kind_q)
        KIND_PUSH_FRONT: begin
          if (full) begin
            st_d = ST_FULL;
          end else begin
            if (!eq) begin
              b_we = 1'b1;
              bh_d = b_prev;
              bc_d = bc_q + ONE_C;
            end else begin
              fc_d = fc_q + ONE_C;
            end
            f_we    = 1'b1;
            f_waddr = f_prev;
            fh_d    = f_prev;
          end
        end
        KIND_PUSH_MIDDLE: begin
          if (full) begin
            st_d = ST_FULL;
          end else if (eq) begin
            f_we = 1'b1;
            fc_d = fc_q + ONE_C;
          end else begin
            b_we    = 1'b1;
            bh_d    = b_prev;
            bc_d    = bc_q + ONE_C;
            f_we    = 1'b1;
            f_waddr = f_last;
          end
        end
        KIND_PUSH_BACK: begin
          if (full) begin
            st_d = ST_FULL;
          end else if (f_empty) begin
            f_we = 1'b1;
            fc_d = fc_q + ONE_C;
          end else begin
            if (eq) begin
              f_we    = 1'b1;
              f_wdata = b_rdata;
              fc_d    = fc_q + ONE_C;
              bh_d    = ring_inc(bh_q);
            end else begin
              bc_d = bc_q + ONE_C;
            end
            b_we    = 1'b1;
            b_waddr = b_end;
            b_wdata = val_q;
          end
        end
        KIND_POP_FRONT: begin
          if (f_empty) begin
            st_d = ST_EMPTY;
          end else begin
            ret_d = f_rdata;
            fh_d  = ring_inc(fh_q);
            if (eq) begin
              f_we    = 1'b1;
              f_wdata = b_rdata;
              bh_d    = ring_inc(bh_q);
              bc_d    = bc_q - ONE_C;
            end else begin
              fc_d = fc_q - ONE_C;
            end
          end
        end
        KIND_POP_MIDDLE: begin
          if (f_empty) begin
            st_d = ST_EMPTY;
          end else begin
            ret_d = f_rdata;
            if (eq) begin
              f_we    = 1'b1;
              f_waddr = f_last;
              f_wdata = b_rdata;
              bh_d    = ring_inc(bh_q);
              bc_d    = bc_q - ONE_C;
            end else begin
              fc_d = fc_q - ONE_C;
            end
          end
        end
        KIND_POP_BACK: begin
          if (f_empty) begin
            st_d = ST_EMPTY;
          end else if (b_empty) begin
            ret_d = f_rdata;
            fc_d  = fc_q - ONE_C;
          end else begin
            ret_d = b_rdata;
            if (!eq) begin
              b_we = 1'b1;
              bh_d = b_prev;
              fc_d = fc_q - ONE_C;
            end else begin
              bc_d = bc_q - ONE_C;
            end
          end
        end
        default: begin
          st_d = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q <= '0;
      fc_q <= '0;
      bh_q <= '0;
      bc_q <= '0;
    end else begin
      fh_q <= fh_d;
      fc_q <= fc_d;
      bh_q <= bh_d;
      bc_q <= bc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      val_q  <= val_ext[DATA_WIDTH-1:0];
    end
    if (cmd_i.wr) begin
      ret_q <= ret_d;
      st_q  <= st_d;
    end
  end

  fmbq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (HALF_DEPTH),
    .AW    (PW)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  fmbq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (HALF_DEPTH),
    .AW    (PW)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign ret_ext        = 64'(ret_q);
  assign popped_value_o = ret_ext[VALUE_W-1:0];
  assign status_o       = st_q;

endmodule

@@ design/front_middle_back_queue_unit.sv @@
// front_middle_back_queue_unit: top level, controller plus datapath.
// An accepted beat runs a registered RAM read pass, then a write pass, at whose end
// the result beat (done_o) is registered; a new beat can be taken in the write pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears heads, counts and the sequencer; the RAMs are not cleared.
// Depends on fmbq_pkg, fmbq_ctrl, fmbq_dp, fmbq_ram.
module front_middle_back_queue_unit
  import fmbq_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      done_o,
  output logic signed [VALUE_W-1:0] popped_value_o,
  output logic [STATUS_W-1:0]       status_o
);

  fmbq_cmd_t cmd;

  fmbq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  fmbq_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted beat did not start a read pass");

  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("read pass longer than one cycle");

  a_done_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o, 2))
    else $error("result beat without an accepted command");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_EMPTY || status_o == ST_FULL)) |-> (popped_value_o == '0))
    else $error("failed operation returned nonzero data");
`endif

endmodule
